/* sv/frame_pacing_duplicator_macros.svh */
// Assertion macros shared by the frame pacing duplicator RTL.
// Include by bare file name; needs a clk and an active-low rst_n in scope.
`ifndef FRAME_PACING_DUPLICATOR_MACROS_SVH
`define FRAME_PACING_DUPLICATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpd assertion failed");

// Next-cycle implication, disabled during reset
`define FPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpd assertion failed");

`endif

/* sv/fpd_pkg.sv */
// Package for the frame pacing duplicator: word types, sequencer states
// and register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

    // Input word
    typedef struct packed {
        logic [63:0] timestamp;
        logic [31:0] overhead_ticks;
    } fpd_in_t;

    // Result word
    typedef struct packed {
        logic [15:0] copy_count;
        logic [31:0] measured_rate;
        logic        rate_valid;
        logic        first_frame;
    } fpd_out_t;

    // Configuration register indexes
    localparam logic [1:0] REG_TIMER_FREQ      = 2'd0;
    localparam logic [1:0] REG_TARGET_RATE     = 2'd1;
    localparam logic [1:0] REG_WEIGHT_OVERRIDE = 2'd2;
    localparam logic [1:0] REG_OVERHEAD_COMP   = 2'd3;

    localparam logic [31:0] TARGET_RATE_RESET = 32'd1966080;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMP,
        ST_DIV_RATE,
        ST_RATE,
        ST_DIV_WEIGHT,
        ST_SUM,
        ST_OUT
    } fpd_state_t;

endpackage

`default_nettype wire

/* sv/frame_pacing_duplicator.sv */
// Frame pacing duplicator: copies-per-frame from timer stamps, one shared
// restoring divider (one quotient bit per cycle) run up to twice per frame.
// First frame or stalled time goes from check straight to output; the computed
// path runs up to two divider passes, then the sum, before the output load.
// One word at a time: in_stall is high from accept until the result is loaded.
// Reset: asynchronous, active low; clears state, stamps and config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module frame_pacing_duplicator #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire fpd_pkg::fpd_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output fpd_pkg::fpd_out_t     out_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [31:0]      cfg_data
);
    import fpd_pkg::*;

    // Dividend width, counter width, count field width
    localparam int DW  = 32 + FRAC_BITS;
    localparam int CW  = $clog2(DW);
    localparam int NW  = DW + 1 - FRAC_BITS;
    localparam logic [NW-1:0] COUNT_MAX = (NW'(1) << COUNT_BITS) - NW'(1);

    // Configuration
    logic [31:0] timer_freq_reg;
    logic [31:0] target_rate_reg;
    logic [31:0] weight_override_reg;
    logic        comp_on_reg;

    // Block state
    logic [63:0]          last_stamp_reg, last_stamp_next;
    logic [31:0]          penalty_reg, penalty_next;
    logic [FRAC_BITS-1:0] leftover_reg, leftover_next;

    // Sequencer and working registers
    fpd_state_t  state_reg, state_next;
    fpd_in_t     in_hold_reg, in_hold_next;
    logic [63:0] diff_reg, diff_next;
    logic [DW-1:0] weight_reg, weight_next;
    fpd_out_t    res_reg, res_next;
    fpd_out_t    out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    // Shared divider
    logic [63:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [63:0]   dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [64:0]   trial;
    logic          trial_ge;
    logic [63:0]   rem_step;
    logic [DW-1:0] quo_step;
    logic          div_last;

    // Compensation and sum helpers
    logic [31:0]   pen_half;
    logic [31:0]   ovh_sub;
    logic [DW:0]   wsum;
    logic [NW-1:0] count_raw;
    logic [NW-1:0] count_sat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Divider step: shift in next dividend bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DW-1]};
        trial_ge = (trial >= {1'b0, dvs_reg});
        rem_step = trial_ge ? 64'(trial - {1'b0, dvs_reg}) : trial[63:0];
        quo_step = {quo_reg[DW-2:0], trial_ge};
        div_last = (cnt_reg == CW'(DW - 1));
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_freq_reg      <= '0;
            target_rate_reg     <= TARGET_RATE_RESET;
            weight_override_reg <= '0;
            comp_on_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMER_FREQ:      timer_freq_reg      <= cfg_data;
                REG_TARGET_RATE:     target_rate_reg     <= cfg_data;
                REG_WEIGHT_OVERRIDE: weight_override_reg <= cfg_data;
                REG_OVERHEAD_COMP:   comp_on_reg         <= cfg_data[0];
                default:             comp_on_reg         <= comp_on_reg;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            last_stamp_reg <= '0;
            penalty_reg    <= '0;
            leftover_reg   <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            last_stamp_reg <= last_stamp_next;
            penalty_reg    <= penalty_next;
            leftover_reg   <= leftover_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_hold_reg <= in_hold_next;
        diff_reg    <= diff_next;
        weight_reg  <= weight_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        in_hold_next    = in_hold_reg;
        diff_next       = diff_reg;
        weight_next     = weight_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        last_stamp_next = last_stamp_reg;
        penalty_next    = penalty_reg;
        leftover_next   = leftover_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dvs_next        = dvs_reg;
        cnt_next        = cnt_reg;

        pen_half  = in_hold_reg.overhead_ticks >> 1;
        ovh_sub   = in_hold_reg.overhead_ticks - pen_half;
        wsum      = {1'b0, weight_reg} + {{(DW + 1 - FRAC_BITS){1'b0}}, leftover_reg};
        count_raw = wsum[DW:FRAC_BITS];
        count_sat = (count_raw > COUNT_MAX) ? COUNT_MAX : count_raw;

        // Output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_hold_next = in_data;
                    state_next   = ST_CHECK;
                end
            end

            // First frame or time not advancing
            ST_CHECK:
            begin
                diff_next       = in_hold_reg.timestamp - last_stamp_reg;
                last_stamp_next = in_hold_reg.timestamp;
                res_next.measured_rate = '0;
                res_next.rate_valid    = 1'b0;
                if ((last_stamp_reg == '0) || (diff_next == '0) || diff_next[63])
                begin
                    res_next.copy_count  = 16'd1;
                    res_next.first_frame = 1'b1;
                    state_next           = ST_OUT;
                end
                else
                begin
                    res_next.first_frame = 1'b0;
                    state_next           = ST_COMP;
                end
            end

            // Override weight or overhead compensation, then load divider
            ST_COMP:
            begin
                rem_next = '0;
                quo_next = {timer_freq_reg, {FRAC_BITS{1'b0}}};
                cnt_next = '0;
                dvs_next = diff_reg;
                if (weight_override_reg != '0)
                begin
                    weight_next = DW'(weight_override_reg);
                    state_next  = ST_SUM;
                end
                else if (comp_on_reg && (in_hold_reg.overhead_ticks != '0))
                begin
                    penalty_next = pen_half;
                    if ({32'd0, ovh_sub} >= diff_reg)
                    begin
                        weight_next = '0;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        dvs_next   = diff_reg - {32'd0, ovh_sub};
                        state_next = ST_DIV_RATE;
                    end
                end
                else if (comp_on_reg)
                begin
                    penalty_next = penalty_reg >> 1;
                    dvs_next     = diff_reg + {33'd0, penalty_reg[31:1]};
                    state_next   = ST_DIV_RATE;
                end
                else
                begin
                    state_next = ST_DIV_RATE;
                end
            end

            // rate = (timer_freq << FRAC_BITS) / ticks
            ST_DIV_RATE:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + CW'(1);
                if (div_last)
                begin
                    state_next = ST_RATE;
                end
            end

            // Zero rate gives zero weight; else start weight division
            ST_RATE:
            begin
                if (quo_reg == '0)
                begin
                    weight_next = '0;
                    state_next  = ST_SUM;
                end
                else
                begin
                    res_next.measured_rate = (|quo_reg[DW-1:32]) ? 32'hFFFF_FFFF
                                                                 : quo_reg[31:0];
                    res_next.rate_valid    = 1'b1;
                    dvs_next   = {{(64 - DW){1'b0}}, quo_reg};
                    rem_next   = '0;
                    quo_next   = {target_rate_reg, {FRAC_BITS{1'b0}}};
                    cnt_next   = '0;
                    state_next = ST_DIV_WEIGHT;
                end
            end

            // weight = (target_rate << FRAC_BITS) / rate
            ST_DIV_WEIGHT:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + CW'(1);
                if (div_last)
                begin
                    weight_next = quo_step;
                    state_next  = ST_SUM;
                end
            end

            // Add leftover, split count and fraction, saturate count
            ST_SUM:
            begin
                leftover_next       = wsum[FRAC_BITS-1:0];
                res_next.copy_count = count_sat[15:0];
                state_next          = ST_OUT;
            end

            // Load result word once the output slot is free
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
`include "frame_pacing_duplicator_macros.svh"

    `FPD_ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state_reg == ST_CHECK)
    `FPD_ASSERT_NEXT(a_out_load, (state_reg == ST_OUT) && (!out_valid_reg || !out_stall),
        out_valid_reg && (state_reg == ST_IDLE))
    `FPD_ASSERT_NOW(a_first_word, out_valid_reg && out_reg.first_frame,
        (out_reg.copy_count == 16'd1) && !out_reg.rate_valid)
    `FPD_ASSERT_NOW(a_rate_nonzero, out_valid_reg && out_reg.rate_valid,
        out_reg.measured_rate != '0)
    `FPD_ASSERT_NOW(a_rate_after_div, state_reg == ST_RATE,
        $past(state_reg) == ST_DIV_RATE)

endmodule

`default_nettype wire
